@@ design/ccc_pkg.sv @@
`timescale 1ns / 1ps

package ccc_pkg;

   localparam int ENERGY_W = 48;
   localparam int SUM_W    = ENERGY_W + 2;
   localparam int PROD_W   = 33;
   localparam int DIV_STEPS = 6;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [ENERGY_W-1:0] EMPTY_RESET = -48'sd864000000000;
   localparam logic [15:0] EFF_RESET      = 16'd57016;
   localparam logic [9:0]  INTERVAL_RESET = 10'd300;

   localparam int EMPTY_DIVISOR = 20;
   localparam int SEC_LIMIT     = 60;
   localparam int MIN_LIMIT     = 60;
   localparam int HOUR_LIMIT    = 24;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   localparam logic [1:0] CSR_EMPTY    = 2'd0;
   localparam logic [1:0] CSR_EFF      = 2'd1;
   localparam logic [1:0] CSR_INTERVAL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_ACC,
      ST_CLEAR,
      ST_DIV,
      ST_LOAD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic ld_input;
      logic mul1;
      logic mul2;
      logic acc;
      logic clear;
      logic div_step;
      logic load;
      logic ld_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } stat_type;

   // clamp to [min(empty, 0), 0]
   function automatic logic signed [ENERGY_W-1:0] clamp_energy(
      input logic signed [SUM_W-1:0]    v,
      input logic signed [ENERGY_W-1:0] empty
   );
      logic signed [SUM_W-1:0] lo;
      logic signed [ENERGY_W-1:0] res;
      lo = empty[ENERGY_W-1] ? SUM_W'(empty) : '0;
      if (v < lo) begin
         res = lo[ENERGY_W-1:0];
      end else if (v > 0) begin
         res = '0;
      end else begin
         res = v[ENERGY_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ design/ccc_ctrl.sv @@
`timescale 1ns / 1ps

module ccc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_op,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  ccc_pkg::stat_type  stat,
   output ccc_pkg::cmd_type   cmd
);

   ccc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ccc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.ld_input = 1'b1;
               case (req_op)
                  ccc_pkg::OP_TICK:  state_in = ccc_pkg::ST_MUL1;
                  ccc_pkg::OP_CLEAR: state_in = ccc_pkg::ST_CLEAR;
                  ccc_pkg::OP_LOAD:  state_in = ccc_pkg::ST_DIV;
                  default:           state_in = ccc_pkg::ST_DONE;
               endcase
            end
         end
         ccc_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ccc_pkg::ST_MUL2;
         end
         ccc_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ccc_pkg::ST_ACC;
         end
         ccc_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ccc_pkg::ST_DONE;
         end
         ccc_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ccc_pkg::ST_DONE;
         end
         ccc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ccc_pkg::ST_LOAD;
            end
         end
         ccc_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ccc_pkg::ST_DONE;
         end
         ccc_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.ld_out = 1'b1;
               state_in   = ccc_pkg::ST_IDLE;
            end
         end
         default: state_in = ccc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.ld_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

@@ design/ccc_datapath.sv @@
`timescale 1ns / 1ps

module ccc_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ccc_pkg::cmd_type                        cmd,
   output ccc_pkg::stat_type                       stat,
   input  logic                                    csr_we,
   input  logic [1:0]                              csr_addr,
   input  logic [ccc_pkg::ENERGY_W-1:0]            csr_wdata,
   input  logic [15:0]                             in_voltage,
   input  logic signed [15:0]                      in_current,
   input  logic signed [ccc_pkg::ENERGY_W-1:0]     in_saved,
   output logic [4:0]                              out_hours,
   output logic [5:0]                              out_minutes,
   output logic [5:0]                              out_seconds,
   output logic signed [ccc_pkg::ENERGY_W-1:0]     out_energy,
   output logic                                    out_strobe
);

   localparam int EW = ccc_pkg::ENERGY_W;
   localparam int SW = ccc_pkg::SUM_W;
   localparam int PW = ccc_pkg::PROD_W;

   // configuration
   logic signed [EW-1:0] empty_ff;
   logic [15:0]          eff_ff;
   logic [9:0]           interval_ff;

   // clock and energy state
   logic [5:0]           sec_ff, sec_in;
   logic [5:0]           min_ff, min_in;
   logic [4:0]           hour_ff, hour_in;
   logic signed [EW-1:0] acc_ff, acc_in;
   logic signed [EW-1:0] last_ff, last_in;
   logic [9:0]           save_cnt_ff, save_cnt_in;
   logic                 strobe_ff, strobe_in;

   // operands and intermediates
   logic [15:0]          volt_ff;
   logic signed [15:0]   cur_ff;
   logic signed [EW-1:0] saved_ff;
   logic signed [PW-1:0] prod_ff;
   logic                 cur_pos_ff;
   logic signed [PW-1:0] pwr_ff;
   logic [EW-1:0]        dvd_ff;
   logic [EW-1:0]        quo_ff;
   logic                 dneg_ff;
   logic [ccc_pkg::DIV_CNT_W-1:0] dcnt_ff;

   // output register
   logic [4:0]           o_hours_ff;
   logic [5:0]           o_min_ff;
   logic [5:0]           o_sec_ff;
   logic signed [EW-1:0] o_energy_ff;
   logic                 o_strobe_ff;

   logic [EW-1:0]        empty_mag;
   logic [5:0]           div_rem;
   logic [9:0]           div_fix;
   logic [EW-1:0]        quo_step;
   logic [31:0]          scaled_hi;
   logic [47:0]          scaled;
   logic signed [SW-1:0] tick_sum;
   logic signed [EW-1:0] tick_acc;
   logic signed [EW:0]   quo_s;
   logic signed [SW-1:0] load_sum;
   logic signed [EW-1:0] load_acc;
   logic [10:0]          save_next;

   assign empty_mag = empty_ff[EW-1] ? EW'(-empty_ff) : empty_ff;
   assign stat.div_last = dcnt_ff == ccc_pkg::DIV_CNT_W'(ccc_pkg::DIV_STEPS - 1);

   // divide by 20 as (x / 4) / 5: shift-add series for 1/5, then remainder fix-up
   assign div_rem = dvd_ff[5:0] - quo_ff[5:0] * 6'd5;
   assign div_fix = 10'(div_rem) * 10'd13;

   always_comb begin
      case (dcnt_ff)
         ccc_pkg::DIV_CNT_W'(0): quo_step = (dvd_ff >> 3) + (dvd_ff >> 4);
         ccc_pkg::DIV_CNT_W'(1): quo_step = quo_ff + (quo_ff >> 4);
         ccc_pkg::DIV_CNT_W'(2): quo_step = quo_ff + (quo_ff >> 8);
         ccc_pkg::DIV_CNT_W'(3): quo_step = quo_ff + (quo_ff >> 16);
         ccc_pkg::DIV_CNT_W'(4): quo_step = quo_ff + (quo_ff >> 32);
         default:                quo_step = quo_ff + EW'(div_fix[9:6]);
      endcase
   end

   assign scaled    = prod_ff[31:0] * eff_ff;
   assign scaled_hi = 32'(scaled[47:16]);
   assign tick_sum  = SW'(acc_ff) + SW'(pwr_ff);
   assign tick_acc  = ccc_pkg::clamp_energy(tick_sum, empty_ff);
   assign quo_s     = dneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign load_sum  = SW'(saved_ff) + SW'(quo_s);
   assign load_acc  = ccc_pkg::clamp_energy(load_sum, empty_ff);
   assign save_next = {1'b0, save_cnt_ff} + 11'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff    <= ccc_pkg::EMPTY_RESET;
         eff_ff      <= ccc_pkg::EFF_RESET;
         interval_ff <= ccc_pkg::INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            ccc_pkg::CSR_EMPTY:    empty_ff    <= csr_wdata;
            ccc_pkg::CSR_EFF:      eff_ff      <= csr_wdata[15:0];
            ccc_pkg::CSR_INTERVAL: interval_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      acc_in      = acc_ff;
      last_in     = last_ff;
      save_cnt_in = save_cnt_ff;
      strobe_in   = strobe_ff;
      if (cmd.ld_input) begin
         strobe_in = 1'b0;
      end
      if (cmd.acc) begin
         acc_in = tick_acc;
         if (sec_ff == 6'(ccc_pkg::SEC_LIMIT - 1)) begin
            sec_in = '0;
            if (min_ff == 6'(ccc_pkg::MIN_LIMIT - 1)) begin
               min_in = '0;
               if (hour_ff == 5'(ccc_pkg::HOUR_LIMIT - 1)) begin
                  hour_in = '0;
               end else begin
                  hour_in = hour_ff + 5'd1;
               end
            end else begin
               min_in = min_ff + 6'd1;
            end
         end else begin
            sec_in = sec_ff + 6'd1;
         end
         if (save_next > {1'b0, interval_ff}) begin
            save_cnt_in = '0;
            if (last_ff != tick_acc) begin
               last_in   = tick_acc;
               strobe_in = 1'b1;
            end
         end else begin
            save_cnt_in = save_next[9:0];
         end
      end
      if (cmd.clear) begin
         acc_in = '0;
      end
      if (cmd.load) begin
         acc_in  = load_acc;
         last_in = load_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff      <= '0;
         min_ff      <= '0;
         hour_ff     <= '0;
         acc_ff      <= '0;
         last_ff     <= '0;
         save_cnt_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         sec_ff      <= sec_in;
         min_ff      <= min_in;
         hour_ff     <= hour_in;
         acc_ff      <= acc_in;
         last_ff     <= last_in;
         save_cnt_ff <= save_cnt_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_input) begin
         volt_ff  <= in_voltage;
         cur_ff   <= in_current;
         saved_ff <= in_saved;
         dvd_ff   <= empty_mag >> 2;
         dneg_ff  <= empty_ff[EW-1];
         dcnt_ff  <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_step;
         dcnt_ff <= dcnt_ff + ccc_pkg::DIV_CNT_W'(1);
      end
      if (cmd.mul1) begin
         prod_ff    <= $signed({1'b0, volt_ff}) * cur_ff;
         cur_pos_ff <= !cur_ff[15] && (cur_ff != 16'sd0);
      end
      if (cmd.mul2) begin
         pwr_ff <= cur_pos_ff ? $signed({1'b0, scaled_hi}) : prod_ff;
      end
      if (cmd.ld_out) begin
         o_hours_ff  <= hour_ff;
         o_min_ff    <= min_ff;
         o_sec_ff    <= sec_ff;
         o_energy_ff <= acc_ff;
         o_strobe_ff <= strobe_ff;
      end
   end

   assign out_hours   = o_hours_ff;
   assign out_minutes = o_min_ff;
   assign out_seconds = o_sec_ff;
   assign out_energy  = o_energy_ff;
   assign out_strobe  = o_strobe_ff;

endmodule

@@ design/coulomb_counter_with_clock_core.sv @@
`timescale 1ns / 1ps
// battery energy gauge with time-of-day clock
// req channel: one transaction per operation, kind in req_tuser
//   (tick, charging-complete clear, load saved energy), operands in req_tdata
// rsp channel: exactly one transaction per request carrying the clock,
//   the clamped energy count and the save strobe (rsp_tuser)
// csr port: csr_we writes csr_wdata to register csr_addr
//   (0 empty level, 1 charging efficiency q0.16, 2 save interval)
// a tick runs two chained multiplies (power, then efficiency scaling)
//   and the add/clamp stage before the response
// a load runs the six-step shift-add divide of the empty level by 20,
//   then loads; clear just zeroes the count; an unused code only responds
// one operation is in flight at a time; req_tready is high again once the
//   result sits in the output register, so a new request can be taken
//   while a previous response still waits, but not before the current
//   operation has been moved into the output register
// when rsp_tready is low the response holds and a finished operation
//   waits for the output register to free up
// synchronous reset clears the clock, energy count, last saved value and
//   save counter and restores the register defaults

module coulomb_counter_with_clock_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // battery_voltage_mv, battery_current_ma, saved_energy
   input  logic [1:0]  req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // hours, minutes, seconds, energy_count, zero fill
   output logic        rsp_tuser,  // save_strobe
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [47:0] csr_wdata
);

   ccc_pkg::cmd_type  cmd;
   ccc_pkg::stat_type stat;

   logic [4:0]                          hours;
   logic [5:0]                          minutes;
   logic [5:0]                          seconds;
   logic signed [ccc_pkg::ENERGY_W-1:0] energy;
   logic                                strobe;

   ccc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ccc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .in_voltage  (req_tdata[15:0]),
      .in_current  ($signed(req_tdata[31:16])),
      .in_saved    ($signed(req_tdata[79:32])),
      .out_hours   (hours),
      .out_minutes (minutes),
      .out_seconds (seconds),
      .out_energy  (energy),
      .out_strobe  (strobe)
   );

   assign rsp_tdata = {7'd0, energy, seconds, minutes, hours};
   assign rsp_tuser = strobe;

endmodule
